// ===== hdl/iast_pkg.sv =====
// Shared types, constants and helper functions of the indentation-aware tokenizer.
`default_nettype none
package iast_pkg;

  // Indentation stack and front-to-back queue sizes
  localparam int INDENT_DEPTH = 32;
  localparam int TOP_W        = $clog2(INDENT_DEPTH);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // Token kinds
  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_NAME    = 6'd1;
  localparam logic [5:0] K_INT     = 6'd2;
  localparam logic [5:0] K_FLOAT   = 6'd3;
  localparam logic [5:0] K_STRING  = 6'd4;
  localparam logic [5:0] K_DEF     = 6'd5;
  localparam logic [5:0] K_INDENT  = 6'd11;
  localparam logic [5:0] K_DEDENT  = 6'd12;
  localparam logic [5:0] K_NEWLINE = 6'd13;
  localparam logic [5:0] K_LPAREN  = 6'd14;
  localparam logic [5:0] K_RPAREN  = 6'd15;
  localparam logic [5:0] K_LBRACK  = 6'd16;
  localparam logic [5:0] K_RBRACK  = 6'd17;
  localparam logic [5:0] K_COMMA   = 6'd18;
  localparam logic [5:0] K_COLON   = 6'd19;
  localparam logic [5:0] K_DOT     = 6'd20;
  localparam logic [5:0] K_PLUS    = 6'd21;
  localparam logic [5:0] K_MINUS   = 6'd22;
  localparam logic [5:0] K_STAR    = 6'd23;
  localparam logic [5:0] K_SLASH   = 6'd24;
  localparam logic [5:0] K_PERCENT = 6'd25;
  localparam logic [5:0] K_EQUAL   = 6'd26;
  localparam logic [5:0] K_EQEQ    = 6'd27;
  localparam logic [5:0] K_NE      = 6'd28;
  localparam logic [5:0] K_LT      = 6'd29;
  localparam logic [5:0] K_LE      = 6'd30;
  localparam logic [5:0] K_GT      = 6'd31;
  localparam logic [5:0] K_GE      = 6'd32;
  localparam logic [5:0] K_STRCHAR = 6'd33;
  localparam logic [5:0] K_ERROR   = 6'd34;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
  localparam logic [2:0] ERR_UNTERM   = 3'd2;
  localparam logic [2:0] ERR_INDENT   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  // Pending odd whitespace in the leading part of a line
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_CR   = 2'd1;
  localparam logic [1:0] PEND_VTFF = 2'd2;

  // Characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_NL_VAL = 8'd10;
  localparam logic [7:0] CH_TB_VAL = 8'd9;

  localparam logic [11:0] COL_MAX  = 12'hFFF;
  localparam logic [15:0] LINE_MAX = 16'hFFFF;
  localparam int          KW_COUNT = 6;

  typedef enum logic [3:0] {
    CC_ALPHA, CC_DIGIT, CC_SPACE, CC_NL, CC_CR, CC_VTFF, CC_HASH,
    CC_QUOTE, CC_OPSTART, CC_SINGLE, CC_OTHER
  } char_class_t;

  typedef enum logic [2:0] {
    LM_IDLE, LM_NAME, LM_INT, LM_FLOAT, LM_STR, LM_ESC, LM_OP
  } lex_mode_t;

  typedef enum logic [1:0] {
    LP_LEAD, LP_CONTENT, LP_TAIL, LP_BLANK
  } line_phase_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_BYTE, SQ_OPEN, SQ_DED, SQ_LPOST, SQ_CONT, SQ_DISP,
    SQ_NLFIN, SQ_NL, SQ_EFIN, SQ_EDED, SQ_EOFTOK, SQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] line_number;
    logic [11:0] column;
    logic [11:0] token_length;
    logic [7:0]  char_value;
    logic [2:0]  error_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        end_of_source;
    logic [7:0]  source_byte;
    char_class_t cls;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_push_t;

  // Saturate a 13-bit count to 12 bits
  function automatic logic [11:0] sat12(input logic [12:0] v);
    return v[12] ? COL_MAX : v[11:0];
  endfunction

  function automatic logic [11:0] inc12(input logic [11:0] v);
    return sat12({1'b0, v} + 13'd1);
  endfunction

  function automatic logic [2:0] kw_len(input int k);
    logic [2:0] r;
    unique case (k)
      0: r = 3'd3;
      1: r = 3'd2;
      2: r = 3'd4;
      3: r = 3'd5;
      4: r = 3'd6;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  // Keyword spelling: def if else while return pass
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
    logic [47:0] s;
    unique case (k)
      0: s = {8'h00, 8'h00, 8'h00, "f", "e", "d"};
      1: s = {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"};
      2: s = {8'h00, 8'h00, "e", "s", "l", "e"};
      3: s = {8'h00, "e", "l", "i", "h", "w"};
      4: s = {"n", "r", "u", "t", "e", "r"};
      default: s = {8'h00, 8'h00, "s", "s", "a", "p"};
    endcase
    return (idx > 3'd5) ? 8'h00 : s[idx * 8 +: 8];
  endfunction

  // Single-character operators; K_EOF means none
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] r;
    unique case (c)
      "(": r = K_LPAREN;
      ")": r = K_RPAREN;
      "[": r = K_LBRACK;
      "]": r = K_RBRACK;
      ",": r = K_COMMA;
      ":": r = K_COLON;
      ".": r = K_DOT;
      "+": r = K_PLUS;
      "-": r = K_MINUS;
      "*": r = K_STAR;
      "/": r = K_SLASH;
      "%": r = K_PERCENT;
      default: r = K_EOF;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/iast_front.sv =====
// Front end: input register stage that classifies each source byte.
`default_nettype none
module iast_front (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  iast_pkg::in_item_t      in_data,
  input  wire                     q_full,
  output iast_pkg::queue_push_t   q_push
);

  logic                   f_valid;
  iast_pkg::queue_item_t  f_item;
  iast_pkg::queue_item_t  f_item_next;
  logic                   accept;
  logic                   push;

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !q_full;

  // Byte classification
  always_comb begin
    logic [7:0] c;
    c = in_data.source_byte;
    f_item_next.end_of_source = in_data.end_of_source;
    f_item_next.source_byte   = c;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
      f_item_next.cls = iast_pkg::CC_ALPHA;
    end else if (c >= "0" && c <= "9") begin
      f_item_next.cls = iast_pkg::CC_DIGIT;
    end else if (c == iast_pkg::CH_SPACE || c == iast_pkg::CH_TAB) begin
      f_item_next.cls = iast_pkg::CC_SPACE;
    end else if (c == iast_pkg::CH_NL) begin
      f_item_next.cls = iast_pkg::CC_NL;
    end else if (c == iast_pkg::CH_CR) begin
      f_item_next.cls = iast_pkg::CC_CR;
    end else if (c == iast_pkg::CH_VT || c == iast_pkg::CH_FF) begin
      f_item_next.cls = iast_pkg::CC_VTFF;
    end else if (c == iast_pkg::CH_HASH) begin
      f_item_next.cls = iast_pkg::CC_HASH;
    end else if (c == iast_pkg::CH_DQ || c == iast_pkg::CH_SQ) begin
      f_item_next.cls = iast_pkg::CC_QUOTE;
    end else if (c == iast_pkg::CH_EQ || c == iast_pkg::CH_BANG ||
                 c == iast_pkg::CH_LT || c == iast_pkg::CH_GT) begin
      f_item_next.cls = iast_pkg::CC_OPSTART;
    end else if (iast_pkg::single_kind(c) != iast_pkg::K_EOF) begin
      f_item_next.cls = iast_pkg::CC_SINGLE;
    end else begin
      f_item_next.cls = iast_pkg::CC_OTHER;
    end
  end

  // Holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      f_item <= f_item_next;
    end
  end

  assign q_push.valid = push;
  assign q_push.item  = f_item;

endmodule
`default_nettype wire

// ===== hdl/iast_queue.sv =====
// Short queue of classified items between the front and back ends.
`default_nettype none
module iast_queue (
  input  wire                     clk,
  input  wire                     rst,
  input  iast_pkg::queue_push_t   q_push,
  output logic                    q_full,
  input  wire                     q_pop,
  output logic                    q_valid,
  output iast_pkg::queue_item_t   q_head
);

  iast_pkg::queue_item_t             slots [iast_pkg::QUEUE_DEPTH];
  logic [iast_pkg::QPTR_W-1:0]       wr_ptr;
  logic [iast_pkg::QPTR_W-1:0]       rd_ptr;
  logic [iast_pkg::QPTR_W:0]         count;
  logic                              do_push;
  logic                              do_pop;

  assign q_full  = (count == (iast_pkg::QPTR_W + 1)'(iast_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_head  = slots[rd_ptr];
  assign do_push = q_push.valid && !q_full;
  assign do_pop  = q_pop && q_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_push.item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/iast_back.sv =====
// Back end: lexer sequencer, indentation stack and result output register.
`default_nettype none
module iast_back (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     q_valid,
  input  iast_pkg::queue_item_t   q_head,
  output logic                    q_pop,
  input  wire                     write_enable,
  input  wire [3:0]               write_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output iast_pkg::out_item_t     out_data
);

  localparam int TW = iast_pkg::TOP_W;

  iast_pkg::seq_state_t   seq, seq_next;
  iast_pkg::queue_item_t  item;
  logic                   col_inc, col_inc_next;

  logic [3:0]             tab_width;
  logic [7:0]             stack_mem [iast_pkg::INDENT_DEPTH];
  logic [TW-1:0]          stack_top, stack_top_next;
  logic                   stk_we;
  logic [TW-1:0]          stk_widx;
  logic [7:0]             top_lvl;

  logic [7:0]             cur_indent, cur_indent_next;
  logic [15:0]            line_cnt, line_cnt_next;
  logic [11:0]            col_cnt, col_cnt_next;
  iast_pkg::line_phase_t  phase, phase_next;
  iast_pkg::lex_mode_t    lex, lex_next;
  logic [11:0]            tstart, tstart_next;
  logic                   quote, quote_next;
  logic [5:0]             hits, hits_next;
  logic                   err, err_next;
  logic [11:0]            tok_len, tok_len_next;
  logic [7:0]             op_byte, op_byte_next;
  logic                   frozen, frozen_next;
  logic [1:0]             pend, pend_next;
  logic [11:0]            pend_col, pend_col_next;

  logic                   st_valid;
  iast_pkg::out_item_t    st;
  logic                   emit_v;
  iast_pkg::out_item_t    em;
  logic                   can_move;
  logic                   step_en;
  logic                   done_go;
  logic                   push_out;

  logic [7:0]             c;
  logic                   is_alnum;
  logic                   fin_emit;
  logic [5:0]             fin_kind;
  logic [11:0]            fin_len;
  logic [2:0]             fin_err;
  logic [11:0]            fin_col;
  logic                   cont_go_disp;
  logic                   ded_more;

  assign c        = item.source_byte;
  assign is_alnum = (item.cls == iast_pkg::CC_ALPHA) || (item.cls == iast_pkg::CC_DIGIT);
  assign top_lvl  = (stack_top == '0) ? 8'd0 : stack_mem[stack_top];
  assign can_move = !out_valid || !out_stall;
  assign step_en  = !st_valid || can_move;
  assign done_go  = (seq == iast_pkg::SQ_DONE) && step_en;
  assign q_pop    = (seq == iast_pkg::SQ_IDLE) && q_valid;
  assign ded_more = (stack_top != '0) && (cur_indent < top_lvl);
  assign fin_col  = iast_pkg::inc12(tstart);

  // Token completion for the current lexer mode
  always_comb begin
    fin_emit = 1'b0;
    fin_kind = iast_pkg::K_NAME;
    fin_len  = tok_len;
    fin_err  = iast_pkg::ERR_NONE;
    unique case (lex)
      iast_pkg::LM_NAME: begin
        fin_emit = 1'b1;
        for (int k = 0; k < iast_pkg::KW_COUNT; k++) begin
          if (hits[k] && tok_len == {9'd0, iast_pkg::kw_len(k)}) begin
            fin_kind = 6'(iast_pkg::K_DEF + 6'(k));
          end
        end
      end
      iast_pkg::LM_INT: begin
        fin_emit = 1'b1;
        fin_kind = iast_pkg::K_INT;
      end
      iast_pkg::LM_FLOAT: begin
        fin_emit = 1'b1;
        fin_kind = iast_pkg::K_FLOAT;
      end
      iast_pkg::LM_OP: begin
        fin_emit = 1'b1;
        fin_len  = 12'd1;
        if (op_byte == iast_pkg::CH_EQ) begin
          fin_kind = iast_pkg::K_EQUAL;
        end else if (op_byte == iast_pkg::CH_LT) begin
          fin_kind = iast_pkg::K_LT;
        end else if (op_byte == iast_pkg::CH_GT) begin
          fin_kind = iast_pkg::K_GT;
        end else begin
          fin_kind = iast_pkg::K_ERROR;
          fin_err  = iast_pkg::ERR_BAD_CHAR;
        end
      end
      iast_pkg::LM_STR, iast_pkg::LM_ESC: begin
        fin_emit = 1'b1;
        fin_kind = iast_pkg::K_ERROR;
        fin_err  = iast_pkg::ERR_UNTERM;
      end
      default: fin_emit = 1'b0;
    endcase
  end

  // Whether a content byte closes the running token and needs dispatching
  always_comb begin
    unique case (lex)
      iast_pkg::LM_NAME:  cont_go_disp = !is_alnum;
      iast_pkg::LM_INT:   cont_go_disp = (item.cls != iast_pkg::CC_DIGIT) && (c != iast_pkg::CH_DOT);
      iast_pkg::LM_FLOAT: cont_go_disp = (item.cls != iast_pkg::CC_DIGIT);
      iast_pkg::LM_OP:    cont_go_disp = (c != iast_pkg::CH_EQ);
      iast_pkg::LM_IDLE:  cont_go_disp = 1'b1;
      default:            cont_go_disp = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      iast_pkg::SQ_IDLE: if (q_valid) seq_next = iast_pkg::SQ_BYTE;
      iast_pkg::SQ_BYTE: begin
        if (step_en) begin
          priority if (item.end_of_source) seq_next = iast_pkg::SQ_EFIN;
          else if (err) seq_next = iast_pkg::SQ_DONE;
          else if (item.cls == iast_pkg::CC_NL) seq_next = iast_pkg::SQ_NLFIN;
          else if (phase == iast_pkg::LP_LEAD) begin
            if (item.cls == iast_pkg::CC_SPACE || item.cls == iast_pkg::CC_HASH ||
                item.cls == iast_pkg::CC_CR || item.cls == iast_pkg::CC_VTFF) begin
              seq_next = iast_pkg::SQ_DONE;
            end else begin
              seq_next = iast_pkg::SQ_OPEN;
            end
          end
          else if (phase == iast_pkg::LP_CONTENT) seq_next = iast_pkg::SQ_CONT;
          else seq_next = iast_pkg::SQ_DONE;
        end
      end
      iast_pkg::SQ_OPEN: begin
        if (step_en) begin
          priority if (cur_indent <= top_lvl) seq_next = iast_pkg::SQ_DED;
          else if (stack_top == TW'(iast_pkg::INDENT_DEPTH - 1)) seq_next = iast_pkg::SQ_DONE;
          else seq_next = iast_pkg::SQ_LPOST;
        end
      end
      iast_pkg::SQ_DED: begin
        if (step_en) begin
          priority if (ded_more) seq_next = iast_pkg::SQ_DED;
          else if (cur_indent != top_lvl) seq_next = iast_pkg::SQ_DONE;
          else seq_next = iast_pkg::SQ_LPOST;
        end
      end
      iast_pkg::SQ_LPOST: begin
        if (step_en) begin
          seq_next = (pend == iast_pkg::PEND_NONE) ? iast_pkg::SQ_DISP : iast_pkg::SQ_DONE;
        end
      end
      iast_pkg::SQ_CONT: begin
        if (step_en) seq_next = cont_go_disp ? iast_pkg::SQ_DISP : iast_pkg::SQ_DONE;
      end
      iast_pkg::SQ_DISP:  if (step_en) seq_next = iast_pkg::SQ_DONE;
      iast_pkg::SQ_NLFIN: if (step_en) seq_next = iast_pkg::SQ_NL;
      iast_pkg::SQ_NL: begin
        if (step_en) seq_next = item.end_of_source ? iast_pkg::SQ_EDED : iast_pkg::SQ_DONE;
      end
      iast_pkg::SQ_EFIN: begin
        if (step_en) begin
          seq_next = (!err && col_cnt != '0) ? iast_pkg::SQ_NL : iast_pkg::SQ_EDED;
        end
      end
      iast_pkg::SQ_EDED: begin
        if (step_en && !(!err && stack_top != '0)) seq_next = iast_pkg::SQ_EOFTOK;
      end
      iast_pkg::SQ_EOFTOK: if (step_en) seq_next = iast_pkg::SQ_DONE;
      iast_pkg::SQ_DONE:   if (done_go) seq_next = iast_pkg::SQ_IDLE;
      default:             seq_next = iast_pkg::SQ_IDLE;
    endcase
  end

  // Lexer state updates and result generation
  always_comb begin
    stack_top_next  = stack_top;
    cur_indent_next = cur_indent;
    line_cnt_next   = line_cnt;
    col_cnt_next    = col_cnt;
    phase_next      = phase;
    lex_next        = lex;
    tstart_next     = tstart;
    quote_next      = quote;
    hits_next       = hits;
    err_next        = err;
    tok_len_next    = tok_len;
    op_byte_next    = op_byte;
    frozen_next     = frozen;
    pend_next       = pend;
    pend_col_next   = pend_col;
    col_inc_next    = col_inc;
    stk_we          = 1'b0;
    stk_widx        = TW'(stack_top + 1'b1);
    emit_v          = 1'b0;
    em.token_kind   = iast_pkg::K_EOF;
    em.line_number  = line_cnt;
    em.column       = 12'd1;
    em.token_length = 12'd0;
    em.char_value   = 8'd0;
    em.error_code   = iast_pkg::ERR_NONE;
    em.last         = 1'b0;

    if (step_en) begin
      unique case (seq)
        iast_pkg::SQ_BYTE: begin
          col_inc_next = !item.end_of_source && !err && (item.cls != iast_pkg::CC_NL);
          if (!item.end_of_source && !err && phase == iast_pkg::LP_LEAD) begin
            unique case (item.cls)
              iast_pkg::CC_SPACE: begin
                if (!frozen) begin
                  logic [8:0] sum;
                  sum = {1'b0, cur_indent} +
                        ((c == iast_pkg::CH_TAB) ? {5'd0, tab_width} : 9'd1);
                  cur_indent_next = sum[8] ? 8'hFF : sum[7:0];
                end
              end
              iast_pkg::CC_HASH: phase_next = iast_pkg::LP_BLANK;
              iast_pkg::CC_CR, iast_pkg::CC_VTFF: begin
                frozen_next = 1'b1;
                if (pend == iast_pkg::PEND_NONE) begin
                  pend_next = (item.cls == iast_pkg::CC_CR) ? iast_pkg::PEND_CR
                                                            : iast_pkg::PEND_VTFF;
                  pend_col_next = col_cnt;
                end
              end
              default: ;
            endcase
          end
        end

        // Push a deeper level, or report overflow
        iast_pkg::SQ_OPEN: begin
          if (cur_indent > top_lvl) begin
            emit_v = 1'b1;
            if (stack_top == TW'(iast_pkg::INDENT_DEPTH - 1)) begin
              em.token_kind = iast_pkg::K_ERROR;
              em.error_code = iast_pkg::ERR_OVERFLOW;
              err_next      = 1'b1;
            end else begin
              em.token_kind  = iast_pkg::K_INDENT;
              stk_we         = 1'b1;
              stack_top_next = TW'(stack_top + 1'b1);
            end
          end
        end

        // Pop one level a cycle while the output does not stall, then check the level matches
        iast_pkg::SQ_DED: begin
          if (ded_more) begin
            emit_v         = 1'b1;
            em.token_kind  = iast_pkg::K_DEDENT;
            stack_top_next = TW'(stack_top - 1'b1);
          end else if (cur_indent != top_lvl) begin
            emit_v        = 1'b1;
            em.token_kind = iast_pkg::K_ERROR;
            em.error_code = iast_pkg::ERR_INDENT;
            err_next      = 1'b1;
          end
        end

        iast_pkg::SQ_LPOST: begin
          unique case (pend)
            iast_pkg::PEND_VTFF: begin
              emit_v          = 1'b1;
              em.token_kind   = iast_pkg::K_ERROR;
              em.error_code   = iast_pkg::ERR_BAD_CHAR;
              em.column       = iast_pkg::inc12(pend_col);
              em.token_length = 12'd1;
              err_next        = 1'b1;
            end
            iast_pkg::PEND_CR: phase_next = iast_pkg::LP_TAIL;
            default:           phase_next = iast_pkg::LP_CONTENT;
          endcase
        end

        // Continue or close the running token
        iast_pkg::SQ_CONT: begin
          unique case (lex)
            iast_pkg::LM_STR: begin
              if (c == (quote ? iast_pkg::CH_DQ : iast_pkg::CH_SQ)) begin
                emit_v          = 1'b1;
                em.token_kind   = iast_pkg::K_STRING;
                em.column       = fin_col;
                em.token_length = iast_pkg::sat12({1'b0, tok_len} + 13'd1);
                lex_next        = iast_pkg::LM_IDLE;
              end else if (c == iast_pkg::CH_BSL) begin
                lex_next     = iast_pkg::LM_ESC;
                tok_len_next = iast_pkg::inc12(tok_len);
              end else begin
                emit_v          = 1'b1;
                em.token_kind   = iast_pkg::K_STRCHAR;
                em.column       = iast_pkg::inc12(col_cnt);
                em.token_length = 12'd1;
                em.char_value   = c;
                tok_len_next    = iast_pkg::inc12(tok_len);
              end
            end
            iast_pkg::LM_ESC: begin
              emit_v          = 1'b1;
              em.token_kind   = iast_pkg::K_STRCHAR;
              em.column       = iast_pkg::inc12(col_cnt);
              em.token_length = 12'd2;
              em.char_value   = (c == iast_pkg::CH_N) ? iast_pkg::CH_NL_VAL :
                                (c == iast_pkg::CH_T) ? iast_pkg::CH_TB_VAL : c;
              lex_next        = iast_pkg::LM_STR;
              tok_len_next    = iast_pkg::inc12(tok_len);
            end
            iast_pkg::LM_OP: begin
              if (c == iast_pkg::CH_EQ) begin
                emit_v          = 1'b1;
                em.token_kind   = (op_byte == iast_pkg::CH_EQ)   ? iast_pkg::K_EQEQ :
                                  (op_byte == iast_pkg::CH_BANG) ? iast_pkg::K_NE :
                                  (op_byte == iast_pkg::CH_LT)   ? iast_pkg::K_LE :
                                                                   iast_pkg::K_GE;
                em.column       = fin_col;
                em.token_length = 12'd2;
                lex_next        = iast_pkg::LM_IDLE;
              end
            end
            iast_pkg::LM_NAME: begin
              if (is_alnum) begin
                for (int k = 0; k < iast_pkg::KW_COUNT; k++) begin
                  if (tok_len >= {9'd0, iast_pkg::kw_len(k)} ||
                      iast_pkg::kw_char(k, tok_len[2:0]) != c) begin
                    hits_next[k] = 1'b0;
                  end
                end
                tok_len_next = iast_pkg::inc12(tok_len);
              end
            end
            iast_pkg::LM_INT: begin
              if (item.cls == iast_pkg::CC_DIGIT) begin
                tok_len_next = iast_pkg::inc12(tok_len);
              end else if (c == iast_pkg::CH_DOT) begin
                lex_next     = iast_pkg::LM_FLOAT;
                tok_len_next = iast_pkg::inc12(tok_len);
              end
            end
            iast_pkg::LM_FLOAT: begin
              if (item.cls == iast_pkg::CC_DIGIT) begin
                tok_len_next = iast_pkg::inc12(tok_len);
              end
            end
            default: ;
          endcase
          if (cont_go_disp && lex != iast_pkg::LM_IDLE) begin
            emit_v          = fin_emit;
            em.token_kind   = fin_kind;
            em.column       = fin_col;
            em.token_length = fin_len;
            em.error_code   = fin_err;
            lex_next        = iast_pkg::LM_IDLE;
            if (fin_err != iast_pkg::ERR_NONE) err_next = 1'b1;
          end
        end

        // From an idle lexer, start a token, emit a single-byte token or error, or enter the line tail
        iast_pkg::SQ_DISP: begin
          if (!err) begin
            unique case (item.cls)
              iast_pkg::CC_HASH, iast_pkg::CC_CR: phase_next = iast_pkg::LP_TAIL;
              iast_pkg::CC_SPACE: ;
              iast_pkg::CC_ALPHA: begin
                lex_next     = iast_pkg::LM_NAME;
                tstart_next  = col_cnt;
                tok_len_next = 12'd1;
                for (int k = 0; k < iast_pkg::KW_COUNT; k++) begin
                  hits_next[k] = (iast_pkg::kw_char(k, 3'd0) == c);
                end
              end
              iast_pkg::CC_DIGIT: begin
                lex_next     = iast_pkg::LM_INT;
                tstart_next  = col_cnt;
                tok_len_next = 12'd1;
                hits_next    = '1;
              end
              iast_pkg::CC_QUOTE: begin
                lex_next     = iast_pkg::LM_STR;
                tstart_next  = col_cnt;
                tok_len_next = 12'd1;
                hits_next    = '1;
                quote_next   = (c == iast_pkg::CH_DQ);
              end
              iast_pkg::CC_OPSTART: begin
                lex_next     = iast_pkg::LM_OP;
                tstart_next  = col_cnt;
                tok_len_next = 12'd1;
                hits_next    = '1;
                op_byte_next = c;
              end
              iast_pkg::CC_SINGLE: begin
                emit_v          = 1'b1;
                em.token_kind   = iast_pkg::single_kind(c);
                em.column       = iast_pkg::inc12(col_cnt);
                em.token_length = 12'd1;
              end
              default: begin
                emit_v          = 1'b1;
                em.token_kind   = iast_pkg::K_ERROR;
                em.error_code   = iast_pkg::ERR_BAD_CHAR;
                em.column       = iast_pkg::inc12(col_cnt);
                em.token_length = 12'd1;
                err_next        = 1'b1;
              end
            endcase
          end
        end

        // Close the token at a line end or at end of source
        iast_pkg::SQ_NLFIN, iast_pkg::SQ_EFIN: begin
          if (seq == iast_pkg::SQ_NLFIN || (!err && col_cnt != '0)) begin
            emit_v          = fin_emit;
            em.token_kind   = fin_kind;
            em.column       = fin_col;
            em.token_length = fin_len;
            em.error_code   = fin_err;
            lex_next        = iast_pkg::LM_IDLE;
            if (fin_err != iast_pkg::ERR_NONE) err_next = 1'b1;
          end
        end

        iast_pkg::SQ_NL: begin
          if (!err) begin
            if (phase == iast_pkg::LP_CONTENT || phase == iast_pkg::LP_TAIL) begin
              emit_v        = 1'b1;
              em.token_kind = iast_pkg::K_NEWLINE;
              em.column     = iast_pkg::inc12(col_cnt);
            end
            if (line_cnt != iast_pkg::LINE_MAX) line_cnt_next = line_cnt + 16'd1;
            col_cnt_next    = '0;
            phase_next      = iast_pkg::LP_LEAD;
            cur_indent_next = '0;
            frozen_next     = 1'b0;
            pend_next       = iast_pkg::PEND_NONE;
            pend_col_next   = '0;
          end
        end

        iast_pkg::SQ_EDED: begin
          if (!err && stack_top != '0) begin
            emit_v         = 1'b1;
            em.token_kind  = iast_pkg::K_DEDENT;
            stack_top_next = TW'(stack_top - 1'b1);
          end
        end

        // EOF, then back to the reset state
        iast_pkg::SQ_EOFTOK: begin
          emit_v          = 1'b1;
          em.token_kind   = iast_pkg::K_EOF;
          stack_top_next  = '0;
          cur_indent_next = '0;
          line_cnt_next   = 16'd1;
          col_cnt_next    = '0;
          phase_next      = iast_pkg::LP_LEAD;
          lex_next        = iast_pkg::LM_IDLE;
          tstart_next     = '0;
          quote_next      = 1'b0;
          hits_next       = '1;
          err_next        = 1'b0;
          tok_len_next    = '0;
          op_byte_next    = '0;
          frozen_next     = 1'b0;
          pend_next       = iast_pkg::PEND_NONE;
          pend_col_next   = '0;
        end

        iast_pkg::SQ_DONE: begin
          if (col_inc) col_cnt_next = iast_pkg::inc12(col_cnt);
        end

        default: ;
      endcase
    end
  end

  assign push_out = (step_en && emit_v && st_valid) || (done_go && st_valid);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= iast_pkg::SQ_IDLE;
      tab_width  <= 4'd4;
      stack_top  <= '0;
      cur_indent <= '0;
      line_cnt   <= 16'd1;
      col_cnt    <= '0;
      phase      <= iast_pkg::LP_LEAD;
      lex        <= iast_pkg::LM_IDLE;
      tstart     <= '0;
      quote      <= 1'b0;
      hits       <= '1;
      err        <= 1'b0;
      tok_len    <= '0;
      op_byte    <= '0;
      frozen     <= 1'b0;
      pend       <= iast_pkg::PEND_NONE;
      pend_col   <= '0;
      col_inc    <= 1'b0;
      st_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      seq        <= seq_next;
      stack_top  <= stack_top_next;
      cur_indent <= cur_indent_next;
      line_cnt   <= line_cnt_next;
      col_cnt    <= col_cnt_next;
      phase      <= phase_next;
      lex        <= lex_next;
      tstart     <= tstart_next;
      quote      <= quote_next;
      hits       <= hits_next;
      err        <= err_next;
      tok_len    <= tok_len_next;
      op_byte    <= op_byte_next;
      frozen     <= frozen_next;
      pend       <= pend_next;
      pend_col   <= pend_col_next;
      col_inc    <= col_inc_next;
      if (write_enable) tab_width <= write_data;
      if (step_en && emit_v) begin
        st_valid <= 1'b1;
      end else if (done_go) begin
        st_valid <= 1'b0;
      end
      if (push_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: item, stack, staged result and output
  always_ff @(posedge clk) begin
    if (q_pop) item <= q_head;
    if (step_en && stk_we) stack_mem[stk_widx] <= cur_indent;
    if (step_en && emit_v) st <= em;
    if (push_out) begin
      out_data      <= st;
      out_data.last <= done_go;
    end
  end

`ifndef SYNTHESIS
  // The staged result is always flushed before the next item is taken
  a_idle_flushed: assert property (@(posedge clk) disable iff (rst)
    (seq == iast_pkg::SQ_IDLE) |-> !st_valid)
    else $error("staged result left behind at item boundary");

  // No token can be open while the leading part of a line is scanned
  a_lead_idle: assert property (@(posedge clk) disable iff (rst)
    (phase == iast_pkg::LP_LEAD) |-> (lex == iast_pkg::LM_IDLE))
    else $error("token open during leading whitespace");

  // End of source leaves a clean lexer
  a_eof_clean: assert property (@(posedge clk) disable iff (rst)
    (seq == iast_pkg::SQ_EOFTOK && step_en) |=>
      (stack_top == '0 && !err && line_cnt == 16'd1 && col_cnt == '0))
    else $error("lexer state not cleared after end of source");

  // A result only moves to the output when the output can take it
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    push_out |-> can_move)
    else $error("output register overwritten while stalled");
`endif

endmodule
`default_nettype wire

// ===== hdl/indent_aware_script_tokenizer.sv =====
// Top level of the indentation-aware script tokenizer.
// Takes one source byte (or an end-of-source mark) per input transaction and
// returns the token results it causes, the final one flagged by last. The front
// end registers and classifies each byte into a four-entry queue, so input keeps
// flowing while the back end works. The back-end sequencer handles one step per
// cycle while the output is not stalled, and emits at most one result per cycle.
// The first non-blank byte of a line emits an INDENT, or one DEDENT per closed
// level. With no error pending, an end-of-source transaction closes a still-open
// last line and emits one DEDENT per open level before the EOF token.
// tab_width is written through write_enable/write_data (reset value 4).
`default_nettype none
module indent_aware_script_tokenizer (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  iast_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output iast_pkg::out_item_t   out_data,
  input  wire                   write_enable,
  input  wire [3:0]             write_data
);

  iast_pkg::queue_push_t  q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  iast_pkg::queue_item_t  q_head;

  iast_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  iast_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  iast_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .write_enable (write_enable),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
`default_nettype wire

// ===== test/indent_aware_script_tokenizer_tb.sv =====
// Self-checking testbench for the indentation-aware script tokenizer.
`timescale 1ns / 100ps
module indent_aware_script_tokenizer_tb;

  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_PER_ITEM  = 36;

  typedef struct {
    bit                   eos;
    logic [7:0]           ch;
    bit                   typed;
    iast_pkg::out_item_t  exp;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  iast_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  iast_pkg::out_item_t  out_data;
  logic                 write_enable = 1'b0;
  logic [3:0]           write_data = 4'd0;

  indent_aware_script_tokenizer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .write_enable (write_enable),
    .write_data   (write_data)
  );

  always #1 clk = ~clk;

  // Lexer state mirrored for prediction
  logic [3:0]             tab_cols;
  logic [7:0]             indent_levels [iast_pkg::INDENT_DEPTH];
  int                     depth_top;
  logic [7:0]             line_indent;
  logic [15:0]            line_no;
  logic [11:0]            col_idx;
  iast_pkg::line_phase_t  phase;
  iast_pkg::lex_mode_t    mode;
  logic [11:0]            tok_start;
  logic [11:0]            tok_len;
  logic                   dbl_quote;
  logic [5:0]             kw_mask;
  logic                   sticky_err;
  logic [7:0]             op_ch;
  logic                   lead_frozen;
  logic [1:0]             pend_ws;
  logic [11:0]            pend_col;

  iast_pkg::out_item_t    step_tokens [$];
  iast_pkg::out_item_t    pending_tokens [$];
  logic [7:0]             prog [$];
  stim_row_t              dir_rows [$];

  string kw_words [6] = '{"def", "if", "else", "while", "return", "pass"};
  string op_chars = "()[],:.+-*/%";
  string two_ops [4] = '{"==", "!=", "<=", ">="};
  string name_chars = "abcdefghijklmnopqrstuvwxyzABXYZ_019";

  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet = 0;
  int sent = 0;
  iast_pkg::out_item_t want;

  // ---------------------------------------------------------------- predictor
  function automatic int sat(int v);
    return (v > 4095) ? 4095 : v;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void clear_lexer();
    for (int i = 0; i < iast_pkg::INDENT_DEPTH; i++) indent_levels[i] = 8'd0;
    depth_top = 0; line_indent = 8'd0; line_no = 16'd1; col_idx = 12'd0;
    phase = iast_pkg::LP_LEAD; mode = iast_pkg::LM_IDLE; tok_start = 12'd0;
    tok_len = 12'd0; dbl_quote = 1'b0; kw_mask = 6'h3F; sticky_err = 1'b0;
    op_ch = 8'd0; lead_frozen = 1'b0; pend_ws = iast_pkg::PEND_NONE; pend_col = 12'd0;
  endfunction

  function void put_token(logic [5:0] k, int c, int len, logic [7:0] ch, logic [2:0] e);
    iast_pkg::out_item_t r;
    if (step_tokens.size() >= MAX_PER_ITEM) return;
    r.token_kind = k; r.line_number = line_no; r.column = 12'(sat(c));
    r.token_length = 12'(sat(len)); r.char_value = ch; r.error_code = e;
    r.last = 1'b0;
    step_tokens.push_back(r);
  endfunction

  function void put_error(logic [2:0] e, int c, int len);
    put_token(iast_pkg::K_ERROR, c, len, 8'd0, e);
    sticky_err = 1'b1;
  endfunction

  function void grow();
    tok_len = 12'(sat(int'(tok_len) + 1));
  endfunction

  function void close_token();
    int col;
    logic [5:0] kind;
    col = int'(tok_start) + 1;
    case (mode)
      iast_pkg::LM_NAME: begin
        kind = iast_pkg::K_NAME;
        for (int k = 0; k < 6; k++)
          if (kw_mask[k] && kw_words[k].len() == int'(tok_len))
            kind = iast_pkg::K_DEF + 6'(k);
        put_token(kind, col, tok_len, 8'd0, iast_pkg::ERR_NONE);
      end
      iast_pkg::LM_INT:   put_token(iast_pkg::K_INT, col, tok_len, 8'd0, iast_pkg::ERR_NONE);
      iast_pkg::LM_FLOAT: put_token(iast_pkg::K_FLOAT, col, tok_len, 8'd0, iast_pkg::ERR_NONE);
      iast_pkg::LM_OP: begin
        if (op_ch == iast_pkg::CH_EQ)
          put_token(iast_pkg::K_EQUAL, col, 1, 8'd0, iast_pkg::ERR_NONE);
        else if (op_ch == iast_pkg::CH_LT)
          put_token(iast_pkg::K_LT, col, 1, 8'd0, iast_pkg::ERR_NONE);
        else if (op_ch == iast_pkg::CH_GT)
          put_token(iast_pkg::K_GT, col, 1, 8'd0, iast_pkg::ERR_NONE);
        else put_error(iast_pkg::ERR_BAD_CHAR, col, 1);
      end
      iast_pkg::LM_STR, iast_pkg::LM_ESC: put_error(iast_pkg::ERR_UNTERM, col, tok_len);
      default: ;
    endcase
    mode = iast_pkg::LM_IDLE;
  endfunction

  function void begin_token(iast_pkg::lex_mode_t m, int pos);
    mode = m; tok_start = 12'(pos); tok_len = 12'd1; kw_mask = 6'h3F;
  endfunction

  function void content_char(logic [7:0] c);
    int pos;
    logic [7:0] d;
    logic [5:0] kind;
    pos = int'(col_idx);
    if (mode == iast_pkg::LM_STR) begin
      if (c == (dbl_quote ? iast_pkg::CH_DQ : iast_pkg::CH_SQ)) begin
        put_token(iast_pkg::K_STRING, int'(tok_start) + 1, int'(tok_len) + 1, 8'd0,
                  iast_pkg::ERR_NONE);
        mode = iast_pkg::LM_IDLE;
      end else if (c == iast_pkg::CH_BSL) begin
        mode = iast_pkg::LM_ESC; grow();
      end else begin
        put_token(iast_pkg::K_STRCHAR, pos + 1, 1, c, iast_pkg::ERR_NONE); grow();
      end
      return;
    end
    if (mode == iast_pkg::LM_ESC) begin
      d = (c == iast_pkg::CH_N) ? iast_pkg::CH_NL_VAL :
          (c == iast_pkg::CH_T) ? iast_pkg::CH_TB_VAL : c;
      put_token(iast_pkg::K_STRCHAR, pos + 1, 2, d, iast_pkg::ERR_NONE);
      mode = iast_pkg::LM_STR; grow();
      return;
    end
    if (mode == iast_pkg::LM_NAME) begin
      if (is_alpha(c) || is_digit(c)) begin
        for (int k = 0; k < 6; k++)
          if (int'(tok_len) >= kw_words[k].len() || kw_words[k][tok_len] != c)
            kw_mask[k] = 1'b0;
        grow();
        return;
      end
      close_token();
    end else if (mode == iast_pkg::LM_INT) begin
      if (is_digit(c)) begin grow(); return; end
      if (c == iast_pkg::CH_DOT) begin mode = iast_pkg::LM_FLOAT; grow(); return; end
      close_token();
    end else if (mode == iast_pkg::LM_FLOAT) begin
      if (is_digit(c)) begin grow(); return; end
      close_token();
    end else if (mode == iast_pkg::LM_OP) begin
      if (c == iast_pkg::CH_EQ) begin
        kind = (op_ch == iast_pkg::CH_EQ)   ? iast_pkg::K_EQEQ :
               (op_ch == iast_pkg::CH_BANG) ? iast_pkg::K_NE :
               (op_ch == iast_pkg::CH_LT)   ? iast_pkg::K_LE : iast_pkg::K_GE;
        put_token(kind, int'(tok_start) + 1, 2, 8'd0, iast_pkg::ERR_NONE);
        mode = iast_pkg::LM_IDLE;
        return;
      end
      close_token();
      if (sticky_err) return;
    end
    if (c == iast_pkg::CH_HASH || c == iast_pkg::CH_CR) begin
      phase = iast_pkg::LP_TAIL; return;
    end
    if (c == iast_pkg::CH_SPACE || c == iast_pkg::CH_TAB) return;
    if (is_alpha(c)) begin
      begin_token(iast_pkg::LM_NAME, pos);
      for (int k = 0; k < 6; k++)
        if (kw_words[k][0] != c) kw_mask[k] = 1'b0;
      return;
    end
    if (is_digit(c)) begin begin_token(iast_pkg::LM_INT, pos); return; end
    if (c == iast_pkg::CH_SQ || c == iast_pkg::CH_DQ) begin
      begin_token(iast_pkg::LM_STR, pos); dbl_quote = (c == iast_pkg::CH_DQ); return;
    end
    if (c == iast_pkg::CH_EQ || c == iast_pkg::CH_BANG ||
        c == iast_pkg::CH_LT || c == iast_pkg::CH_GT) begin
      begin_token(iast_pkg::LM_OP, pos); op_ch = c; return;
    end
    for (int i = 0; i < op_chars.len(); i++)
      if (op_chars[i] == c) begin
        put_token(iast_pkg::K_LPAREN + 6'(i), pos + 1, 1, 8'd0, iast_pkg::ERR_NONE);
        return;
      end
    put_error(iast_pkg::ERR_BAD_CHAR, pos + 1, 1);
  endfunction

  function void open_line();
    if (line_indent > indent_levels[depth_top]) begin
      if (depth_top + 1 >= iast_pkg::INDENT_DEPTH) begin
        put_error(iast_pkg::ERR_OVERFLOW, 1, 0); return;
      end
      depth_top++;
      indent_levels[depth_top] = line_indent;
      put_token(iast_pkg::K_INDENT, 1, 0, 8'd0, iast_pkg::ERR_NONE);
      return;
    end
    while (depth_top > 0 && line_indent < indent_levels[depth_top]) begin
      depth_top--;
      put_token(iast_pkg::K_DEDENT, 1, 0, 8'd0, iast_pkg::ERR_NONE);
    end
    if (line_indent != indent_levels[depth_top]) put_error(iast_pkg::ERR_INDENT, 1, 0);
  endfunction

  function void lead_char(logic [7:0] c);
    int v;
    if (c == iast_pkg::CH_SPACE || c == iast_pkg::CH_TAB) begin
      if (!lead_frozen) begin
        v = int'(line_indent) + ((c == iast_pkg::CH_TAB) ? int'(tab_cols) : 1);
        line_indent = (v > 255) ? 8'd255 : 8'(v);
      end
      return;
    end
    if (c == iast_pkg::CH_HASH) begin phase = iast_pkg::LP_BLANK; return; end
    if (c == iast_pkg::CH_CR || c == iast_pkg::CH_VT || c == iast_pkg::CH_FF) begin
      lead_frozen = 1'b1;
      if (pend_ws == iast_pkg::PEND_NONE) begin
        pend_ws = (c == iast_pkg::CH_CR) ? iast_pkg::PEND_CR : iast_pkg::PEND_VTFF;
        pend_col = col_idx;
      end
      return;
    end
    open_line();
    if (sticky_err) return;
    if (pend_ws == iast_pkg::PEND_VTFF) begin
      put_error(iast_pkg::ERR_BAD_CHAR, int'(pend_col) + 1, 1); return;
    end
    if (pend_ws == iast_pkg::PEND_CR) begin phase = iast_pkg::LP_TAIL; return; end
    phase = iast_pkg::LP_CONTENT;
    content_char(c);
  endfunction

  function void end_line();
    close_token();
    if (sticky_err) return;
    if (phase == iast_pkg::LP_CONTENT || phase == iast_pkg::LP_TAIL)
      put_token(iast_pkg::K_NEWLINE, int'(col_idx) + 1, 0, 8'd0, iast_pkg::ERR_NONE);
    if (line_no != iast_pkg::LINE_MAX) line_no++;
    col_idx = 12'd0; phase = iast_pkg::LP_LEAD; line_indent = 8'd0;
    lead_frozen = 1'b0; pend_ws = iast_pkg::PEND_NONE; pend_col = 12'd0;
  endfunction

  // Tokens caused by one accepted input transaction
  function void predict_tokens(iast_pkg::in_item_t it);
    step_tokens.delete();
    if (it.end_of_source) begin
      if (!sticky_err && col_idx > 0) end_line();
      if (!sticky_err)
        while (depth_top > 0) begin
          depth_top--;
          put_token(iast_pkg::K_DEDENT, 1, 0, 8'd0, iast_pkg::ERR_NONE);
        end
      put_token(iast_pkg::K_EOF, 1, 0, 8'd0, iast_pkg::ERR_NONE);
      clear_lexer();
    end else if (!sticky_err) begin
      if (it.source_byte == iast_pkg::CH_NL) end_line();
      else begin
        if (phase == iast_pkg::LP_LEAD) lead_char(it.source_byte);
        else if (phase == iast_pkg::LP_CONTENT) content_char(it.source_byte);
        col_idx = 12'(sat(int'(col_idx) + 1));
      end
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] exp);
    if (got !== exp) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        flag_mismatch($sformatf("unexpected token kind %0d", out_data.token_kind));
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", out_data.token_kind, want.token_kind);
        check_field("line_number", out_data.line_number, want.line_number);
        check_field("column", out_data.column, want.column);
        check_field("token_length", out_data.token_length, want.token_length);
        check_field("char_value", out_data.char_value, want.char_value);
        check_field("error_code", out_data.error_code, want.error_code);
        check_field("last", out_data.last, want.last);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("indent_aware_script_tokenizer verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_item(bit eos, logic [7:0] ch, bit typed, iast_pkg::out_item_t exp);
    iast_pkg::in_item_t it;
    it.end_of_source = eos;
    it.source_byte = ch;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_tokens(it);
    if (typed) pending_tokens.push_back(exp);
    else foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    sent++;
  endtask

  task automatic send_prog();
    foreach (prog[i]) send_item(1'b0, prog[i], 1'b0, '0);
    send_item(1'b1, 8'd0, 1'b0, '0);
    prog.delete();
  endtask

  // Lower valid, wait for every outstanding token, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tokens.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tab_width(logic [3:0] w);
    drain();
    @(negedge clk);
    write_enable <= 1'b1;
    write_data <= w;
    @(negedge clk);
    write_enable <= 1'b0;
    tab_cols = w;
  endtask

  // ---------------------------------------------------------------- stimulus table
  function void add_row(bit eos, logic [7:0] ch, bit typed, iast_pkg::out_item_t exp);
    stim_row_t r;
    r.eos = eos; r.ch = ch; r.typed = typed; r.exp = exp;
    dir_rows.push_back(r);
  endfunction

  function void add_row_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(1'b0, s[i], 1'b0, '0);
  endfunction

  function void build_directed();
    // empty source, bad byte with sticky error, ignored byte, end of source
    add_row(1'b1, 8'd0, 1'b1, '{iast_pkg::K_EOF, 16'd1, 12'd1, 12'd0, 8'd0,
                               iast_pkg::ERR_NONE, 1'b1});
    add_row(1'b0, 8'd0, 1'b1, '{iast_pkg::K_ERROR, 16'd1, 12'd1, 12'd1, 8'd0,
                               iast_pkg::ERR_BAD_CHAR, 1'b1});
    add_row(1'b0, 8'hFF, 1'b0, '0);
    add_row(1'b1, 8'hFF, 1'b1, '{iast_pkg::K_EOF, 16'd1, 12'd1, 12'd0, 8'd0,
                                iast_pkg::ERR_NONE, 1'b1});
    // escaped tab in a string, keyword after a tab indent, != then carriage
    // return, and a vertical tab leading a line that dedents
    add_row_text("if(\"\\t\"):\n\treturn!=\rx\n");
    add_row(1'b0, iast_pkg::CH_VT, 1'b0, '0);
    add_row_text("y");
    add_row(1'b1, 8'd0, 1'b0, '0);
  endfunction

  // ---------------------------------------------------------------- source text
  function void add_s(string s);
    for (int i = 0; i < s.len(); i++) prog.push_back(s[i]);
  endfunction

  function void add_token();
    int n;
    logic [7:0] q;
    case ($urandom_range(0, 11))
      0: add_s(kw_words[$urandom_range(0, 5)]);
      1: begin
        prog.push_back(name_chars[$urandom_range(0, 30)]);
        repeat ($urandom_range(0, 5)) prog.push_back(name_chars[$urandom_range(0, 34)]);
      end
      2: add_s($sformatf("%0d", $urandom_range(0, 99999)));
      3: add_s($urandom_range(0, 3) ? $sformatf("%0d.%0d", $urandom_range(0, 99),
               $urandom_range(0, 999)) : "7.");
      4: begin
        q = $urandom_range(0, 1) ? iast_pkg::CH_DQ : iast_pkg::CH_SQ;
        prog.push_back(q);
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            prog.push_back(iast_pkg::CH_BSL);
            prog.push_back(8'($urandom_range(0, 2) == 0 ? iast_pkg::CH_N :
                              $urandom_range(0, 1) ? iast_pkg::CH_T :
                              8'($urandom_range(32, 126))));
          end else begin
            prog.push_back(8'($urandom_range(32, 126)));
          end
        end
        if ($urandom_range(0, 24) != 0) prog.push_back(q);
      end
      5: add_s(two_ops[$urandom_range(0, 3)]);
      6: prog.push_back(op_chars[$urandom_range(0, 11)]);
      7: begin
        case ($urandom_range(0, 3))
          0: prog.push_back(iast_pkg::CH_LT);
          1: prog.push_back(iast_pkg::CH_GT);
          2: prog.push_back(iast_pkg::CH_EQ);
          default: prog.push_back(iast_pkg::CH_BANG);
        endcase
      end
      8: add_s("# note");
      9: begin prog.push_back(iast_pkg::CH_CR); add_s("zz"); end
      10: prog.push_back(8'($urandom_range(0, 255)));
      default: add_s("a(b)[1]");
    endcase
  endfunction

  // Well-formed script lines with random content, plus occasional noise
  function void gen_program();
    int lv [$];
    int nlines, ind, r, n;
    lv.push_back(0);
    nlines = $urandom_range(1, 3);
    for (int l = 0; l < nlines; l++) begin
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(0, 3)) prog.push_back(iast_pkg::CH_SPACE);
        if ($urandom_range(0, 1)) add_s("# c");
        prog.push_back(iast_pkg::CH_NL);
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        ind = lv[$];
      end else if (r < 75) begin
        ind = lv[$] + $urandom_range(1, 4);
        lv.push_back(ind);
      end else if (r < 90 && lv.size() > 1) begin
        n = $urandom_range(0, lv.size() - 2);
        while (lv.size() > n + 1) void'(lv.pop_back());
        ind = lv[$];
      end else begin
        ind = $urandom_range(0, 12);
      end
      if ($urandom_range(0, 9) == 0) prog.push_back(iast_pkg::CH_TAB);
      repeat (ind) prog.push_back(iast_pkg::CH_SPACE);
      if ($urandom_range(0, 19) == 0)
        prog.push_back($urandom_range(0, 2) == 0 ? iast_pkg::CH_VT :
                       $urandom_range(0, 1) ? iast_pkg::CH_FF : iast_pkg::CH_CR);
      repeat ($urandom_range(1, 5)) begin
        add_token();
        r = $urandom_range(0, 9);
        if (r < 7) prog.push_back(iast_pkg::CH_SPACE);
        else if (r == 7) prog.push_back(iast_pkg::CH_TAB);
      end
      if (l < nlines - 1 || $urandom_range(0, 3) != 0) prog.push_back(iast_pkg::CH_NL);
    end
  endfunction

  // Nest one level deeper per line; assumes a tab counts eight columns
  function void gen_nest(int levels);
    for (int k = 1; k <= levels; k++) begin
      repeat (k / 8) prog.push_back(iast_pkg::CH_TAB);
      repeat (k % 8) prog.push_back(iast_pkg::CH_SPACE);
      add_s("a\n");
    end
  endfunction

  task automatic run_random(int count);
    int stop_at;
    stop_at = sent + count;
    while (sent < stop_at) begin
      gen_program();
      send_prog();
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    clear_lexer();
    tab_cols = 4'd4;
    build_directed();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, no idling, reset tab width
    foreach (dir_rows[i]) send_item(dir_rows[i].eos, dir_rows[i].ch, dir_rows[i].typed,
                                    dir_rows[i].exp);
    run_random(10);

    // Sender idle, tab width of one
    set_tab_width(4'd1);
    idle_pct = 53;
    run_random(10);

    // Receiver stalling, tab width of eight, nesting past the stack under a long hold-off
    set_tab_width(4'd8);
    idle_pct = 0;
    stall_pct = 53;
    gen_nest(32);
    hold_left = 400;
    send_prog();
    run_random(10);

    // Both idle, tab width at the field limits
    set_tab_width(4'd15);
    idle_pct = 27;
    stall_pct = 27;
    run_random(10);
    set_tab_width(4'd0);
    run_random(10);

    // Back to full speed with a random tab width
    set_tab_width(4'($urandom_range(1, 8)));
    idle_pct = 0;
    stall_pct = 0;
    run_random(10);

    drain();
    if (pending_tokens.size() > 0)
      flag_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));
    if (mismatches == 0) begin
      $display("indent_aware_script_tokenizer verification clean");
    end else begin
      $display("indent_aware_script_tokenizer verification failed");
    end
    $finish;
  end

endmodule
